// ===== rtl/core/msb_pkg.sv =====
package msb_pkg;

	localparam int NUM_STACKS_DEF = 8;
	localparam int CAPACITY_DEF = 64;
	localparam int VALUE_W = 32;
	localparam int SID_W = 3;

	localparam logic [VALUE_W-1:0] UNDERFLOW_VALUE = 32'h7FFF_FFFF;

	typedef enum logic {
		FUNC_PUSH = 1'b0,
		FUNC_POP  = 1'b1
	} func_t;

	typedef enum logic [1:0] {
		STATUS_DONE      = 2'd0,
		STATUS_OVERFLOW  = 2'd1,
		STATUS_UNDERFLOW = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		FSM_IDLE,
		FSM_TOP,
		FSM_NODE
	} fsm_t;

endpackage

// ===== rtl/core/msb_top_store.sv =====
module msb_top_store import msb_pkg::*; #(
	parameter int NUM_STACKS = NUM_STACKS_DEF,
	parameter int CAPACITY = CAPACITY_DEF,
	parameter int PTR_W = $clog2(CAPACITY + 1),
	parameter int AW = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [PTR_W-1:0] rd_data,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [PTR_W-1:0] wr_data
);

	logic [PTR_W-1:0]      mem_q [NUM_STACKS];
	logic [PTR_W-1:0]      data_q;
	logic [NUM_STACKS-1:0] valid_q;
	logic                  rd_valid_q;

	// An entry never written holds the null code, which the valid bits supply.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			data_q <= mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_valid_q <= valid_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_valid_q ? data_q : PTR_W'(CAPACITY);

endmodule

// ===== rtl/core/msb_node_store.sv =====
module msb_node_store import msb_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF,
	parameter int PTR_W = $clog2(CAPACITY + 1),
	parameter int IDX_W = $clog2(CAPACITY)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               rd_en,
	input  logic [IDX_W-1:0]   rd_addr,
	output logic [VALUE_W-1:0] rd_value,
	output logic [PTR_W-1:0]   rd_link,
	input  logic               wr_en,
	input  logic [IDX_W-1:0]   wr_addr,
	input  logic [VALUE_W-1:0] wr_value,
	input  logic [PTR_W-1:0]   wr_link
);

	logic [VALUE_W+PTR_W-1:0] mem_q [CAPACITY];
	logic [VALUE_W+PTR_W-1:0] data_q;
	logic [IDX_W-1:0]         rd_addr_q;
	logic                     untouched_q;
	logic [PTR_W-1:0]         fill_q;

	// Slots at or above the fill count were never written; their link is the next slot.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= {wr_value, wr_link};
		end
		if (rd_en) begin
			data_q <= mem_q[rd_addr];
			rd_addr_q <= rd_addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			untouched_q <= 1'b1;
		end else begin
			if (rd_en) begin
				untouched_q <= (PTR_W'(rd_addr) >= fill_q);
			end
			if (wr_en && (PTR_W'(wr_addr) == fill_q)) begin
				fill_q <= fill_q + PTR_W'(1);
			end
		end
	end

	assign rd_value = data_q[VALUE_W+PTR_W-1:PTR_W];
	assign rd_link = untouched_q ? (PTR_W'(rd_addr_q) + PTR_W'(1)) : data_q[PTR_W-1:0];

endmodule

// ===== rtl/core/multi_stack_shared_buffer.sv =====
// Sequence: a push, a pop of an empty stack and any item on a stack number out of range
// are finished in the stack-top read state, FSM_TOP; a pop of a non-empty stack then
// goes on to the slot read state, FSM_NODE, for the dependent read of the slot memory.
// No new item is taken until the block is back in idle; busy is high meanwhile.
// Reset: all stacks empty and every slot free; no clearing pass, the block is ready at once.
// The receiver cannot stall: done marks each result for exactly one cycle.
module multi_stack_shared_buffer import msb_pkg::*; #(
	parameter int NUM_STACKS = NUM_STACKS_DEF,
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic                      func,
	input  logic [SID_W-1:0]          stack_id,
	input  logic signed [VALUE_W-1:0] push_value,
	output logic                      done,
	output logic signed [VALUE_W-1:0] pop_value,
	output logic [1:0]                status,
	output logic                      store_full,
	output logic                      stack_empty
);

	localparam int PTR_W = $clog2(CAPACITY + 1);
	localparam int IDX_W = $clog2(CAPACITY);
	localparam int TOP_AW = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
	localparam logic [PTR_W-1:0] NULL_CODE = PTR_W'(CAPACITY);

	fsm_t              state_q, state_d;
	func_t             func_q;
	logic [TOP_AW-1:0] sid_q;
	logic              in_range_q;
	logic [VALUE_W-1:0] val_q;
	logic [PTR_W-1:0]  slot_q, slot_d;
	logic [PTR_W-1:0]  free_head_q, free_head_d;

	logic               done_d, done_q;
	logic [VALUE_W-1:0] pop_value_d, pop_value_q;
	status_t            status_d, status_q;
	logic               store_full_d, store_full_q;
	logic               stack_empty_d, stack_empty_q;

	logic               top_rd_en, top_wr_en;
	logic [TOP_AW-1:0]  top_rd_addr;
	logic [PTR_W-1:0]   top_rd_data, top_wr_data;
	logic               node_rd_en, node_wr_en;
	logic [IDX_W-1:0]   node_rd_addr, node_wr_addr;
	logic [VALUE_W-1:0] node_rd_value, node_wr_value;
	logic [PTR_W-1:0]   node_rd_link, node_wr_link;

	logic accept, in_range, free_null, top_null, link_null;

	assign accept = start && (state_q == FSM_IDLE);
	assign in_range = (32'(stack_id) < 32'(NUM_STACKS));
	assign free_null = (free_head_q >= NULL_CODE);
	assign top_null = (top_rd_data >= NULL_CODE);
	assign link_null = (node_rd_link >= NULL_CODE);

	msb_top_store #(
		.NUM_STACKS(NUM_STACKS),
		.CAPACITY(CAPACITY),
		.PTR_W(PTR_W),
		.AW(TOP_AW)
	) u_top_store (
		.clk(clk),
		.arst_n(arst_n),
		.rd_en(top_rd_en),
		.rd_addr(top_rd_addr),
		.rd_data(top_rd_data),
		.wr_en(top_wr_en),
		.wr_addr(sid_q),
		.wr_data(top_wr_data)
	);

	msb_node_store #(
		.CAPACITY(CAPACITY),
		.PTR_W(PTR_W),
		.IDX_W(IDX_W)
	) u_node_store (
		.clk(clk),
		.arst_n(arst_n),
		.rd_en(node_rd_en),
		.rd_addr(node_rd_addr),
		.rd_value(node_rd_value),
		.rd_link(node_rd_link),
		.wr_en(node_wr_en),
		.wr_addr(node_wr_addr),
		.wr_value(node_wr_value),
		.wr_link(node_wr_link)
	);

	always_comb begin
		state_d = state_q;
		slot_d = slot_q;
		free_head_d = free_head_q;
		done_d = 1'b0;
		pop_value_d = '0;
		status_d = STATUS_DONE;
		store_full_d = free_null;
		stack_empty_d = 1'b1;
		top_rd_en = 1'b0;
		top_rd_addr = TOP_AW'(stack_id);
		top_wr_en = 1'b0;
		top_wr_data = top_rd_data;
		node_rd_en = 1'b0;
		node_rd_addr = free_head_q[IDX_W-1:0];
		node_wr_en = 1'b0;
		node_wr_addr = free_head_q[IDX_W-1:0];
		node_wr_value = val_q;
		node_wr_link = top_rd_data;
		case (state_q)
			FSM_IDLE: begin
				if (accept) begin
					top_rd_en = in_range;
					node_rd_en = !free_null;
					state_d = FSM_TOP;
				end
			end
			FSM_TOP: begin
				if (!in_range_q) begin
					done_d = 1'b1;
					if (func_q == FUNC_PUSH) begin
						status_d = STATUS_OVERFLOW;
					end else begin
						status_d = STATUS_UNDERFLOW;
						pop_value_d = UNDERFLOW_VALUE;
					end
					state_d = FSM_IDLE;
				end else if (func_q == FUNC_PUSH) begin
					done_d = 1'b1;
					state_d = FSM_IDLE;
					if (free_null) begin
						status_d = STATUS_OVERFLOW;
						stack_empty_d = top_null;
					end else begin
						node_wr_en = 1'b1;
						top_wr_en = 1'b1;
						top_wr_data = free_head_q;
						free_head_d = node_rd_link;
						store_full_d = link_null;
						stack_empty_d = 1'b0;
					end
				end else if (top_null) begin
					done_d = 1'b1;
					status_d = STATUS_UNDERFLOW;
					pop_value_d = UNDERFLOW_VALUE;
					state_d = FSM_IDLE;
				end else begin
					node_rd_en = 1'b1;
					node_rd_addr = top_rd_data[IDX_W-1:0];
					slot_d = top_rd_data;
					state_d = FSM_NODE;
				end
			end
			FSM_NODE: begin
				node_wr_en = 1'b1;
				node_wr_addr = slot_q[IDX_W-1:0];
				node_wr_value = node_rd_value;
				node_wr_link = free_head_q;
				top_wr_en = 1'b1;
				top_wr_data = node_rd_link;
				free_head_d = slot_q;
				done_d = 1'b1;
				pop_value_d = node_rd_value;
				store_full_d = 1'b0;
				stack_empty_d = link_null;
				state_d = FSM_IDLE;
			end
			default: begin
				state_d = FSM_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_IDLE;
			free_head_q <= '0;
			done_q <= 1'b0;
		end else begin
			state_q <= state_d;
			free_head_q <= free_head_d;
			done_q <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q <= func_t'(func);
			sid_q <= TOP_AW'(stack_id);
			in_range_q <= in_range;
			val_q <= push_value;
		end
		slot_q <= slot_d;
		pop_value_q <= pop_value_d;
		status_q <= status_d;
		store_full_q <= store_full_d;
		stack_empty_q <= stack_empty_d;
	end

	assign busy = (state_q != FSM_IDLE);
	assign done = done_q;
	assign pop_value = pop_value_q;
	assign status = status_q;
	assign store_full = store_full_q;
	assign stack_empty = stack_empty_q;

endmodule

// ===== tb/sv/tb_multi_stack_shared_buffer.sv =====
module tb_multi_stack_shared_buffer;
	import msb_pkg::*;

	localparam int NSTK = NUM_STACKS_DEF;
	localparam int CAP = CAPACITY_DEF;
	localparam logic [6:0] NULL_SLOT = 7'(CAP);

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		status_t            st;
		logic               full;
		logic               empty;
	} stack_result_t;

	typedef struct {
		func_t              f;
		logic [SID_W-1:0]   sid;
		logic [VALUE_W-1:0] val;
		int                 reps;
		bit                 typed;
		stack_result_t      want;
	} dir_row_t;

	logic                      clk;
	logic                      arst_n;
	logic                      start;
	logic                      busy;
	logic                      func;
	logic [SID_W-1:0]          stack_id;
	logic signed [VALUE_W-1:0] push_value;
	logic                      done;
	logic signed [VALUE_W-1:0] pop_value;
	logic [1:0]                status;
	logic                      store_full;
	logic                      stack_empty;

	logic [VALUE_W-1:0] slot_val [CAP];
	logic [6:0]         slot_link [CAP];
	logic [6:0]         stack_top [NSTK];
	logic [6:0]         free_head;

	stack_result_t pending_results[$];
	dir_row_t      dir_rows[$];
	bit            row_typed;
	stack_result_t row_want;
	int            idle_pct;

	int n_err = 0;
	int n_checked = 0;
	int n_push = 0;
	int n_pop = 0;
	int n_over = 0;
	int n_under = 0;
	int n_full = 0;

	multi_stack_shared_buffer dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.func(func),
		.stack_id(stack_id),
		.push_value(push_value),
		.done(done),
		.pop_value(pop_value),
		.status(status),
		.store_full(store_full),
		.stack_empty(stack_empty)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	function automatic stack_result_t apply_stack_op(func_t f, logic [SID_W-1:0] sid,
			logic [VALUE_W-1:0] v);
		stack_result_t r;
		logic [6:0] s;
		r.value = '0;
		r.st = STATUS_DONE;
		r.empty = 1'b1;
		if (sid >= NSTK) begin
			r.st = (f == FUNC_PUSH) ? STATUS_OVERFLOW : STATUS_UNDERFLOW;
			if (f == FUNC_POP) r.value = UNDERFLOW_VALUE;
		end else if (f == FUNC_PUSH) begin
			if (free_head >= NULL_SLOT) begin
				r.st = STATUS_OVERFLOW;
			end else begin
				s = free_head;
				free_head = slot_link[s];
				slot_link[s] = stack_top[sid];
				stack_top[sid] = s;
				slot_val[s] = v;
			end
			r.empty = stack_top[sid] >= NULL_SLOT;
		end else begin
			if (stack_top[sid] >= NULL_SLOT) begin
				r.st = STATUS_UNDERFLOW;
				r.value = UNDERFLOW_VALUE;
			end else begin
				s = stack_top[sid];
				stack_top[sid] = slot_link[s];
				slot_link[s] = free_head;
				free_head = s;
				r.value = slot_val[s];
			end
			r.empty = stack_top[sid] >= NULL_SLOT;
		end
		r.full = free_head >= NULL_SLOT;
		return r;
	endfunction

	// The expected result is queued at the transfer and checked when done marks it.
	always @(posedge clk) begin
		stack_result_t pred;
		stack_result_t exp_r;
		if (arst_n) begin
			if (start && !busy) begin
				pred = apply_stack_op(func_t'(func), stack_id, push_value);
				pending_results.push_back(row_typed ? row_want : pred);
			end
			if (done) begin
				if (pending_results.size() == 0) begin
					n_err++;
					if (n_err <= 10)
						$display("Unexpected result: value %h status %0d", pop_value, status);
				end else begin
					exp_r = pending_results.pop_front();
					n_checked++;
					if (exp_r.st == STATUS_OVERFLOW) n_over++;
					if (exp_r.st == STATUS_UNDERFLOW) n_under++;
					if (exp_r.full) n_full++;
					if (pop_value !== exp_r.value || status !== exp_r.st ||
							store_full !== exp_r.full || stack_empty !== exp_r.empty) begin
						n_err++;
						if (n_err <= 10)
							$display({"Mismatch on result %0d: value %h/%h status %0d/%0d ",
								"full %b/%b empty %b/%b (expected/actual)"}, n_checked,
								exp_r.value, pop_value, exp_r.st, status, exp_r.full,
								store_full, exp_r.empty, stack_empty);
					end
				end
			end
		end
	end

	task automatic issue(input func_t f, input logic [SID_W-1:0] sid,
			input logic [VALUE_W-1:0] v, input bit typed, input stack_result_t want);
		int gap;
		gap = ($urandom_range(0, 99) < idle_pct) ? $urandom_range(1, 5) : 0;
		@(negedge clk);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		func <= f;
		stack_id <= sid;
		push_value <= v;
		row_typed = typed;
		row_want = want;
		if (f == FUNC_PUSH) n_push++;
		else n_pop++;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		start <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic put_row(input func_t f, input logic [SID_W-1:0] sid,
			input logic [VALUE_W-1:0] v, input int reps, input bit typed,
			input logic [VALUE_W-1:0] w_val, input status_t w_st, input logic w_full,
			input logic w_empty);
		dir_row_t r;
		r.f = f;
		r.sid = sid;
		r.val = v;
		r.reps = reps;
		r.typed = typed;
		r.want.value = w_val;
		r.want.st = w_st;
		r.want.full = w_full;
		r.want.empty = w_empty;
		dir_rows.push_back(r);
	endtask

	function automatic logic [VALUE_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'hFFFF_FFFF;
			3: return 32'h0000_0000;
			default: return $urandom;
		endcase
	endfunction

	initial begin
		int seg_left;
		int push_pct;
		int fixed_sid;
		int phase_items;
		func_t f;
		logic [SID_W-1:0] sid;
		start = 1'b0;
		func = 1'b0;
		stack_id = '0;
		push_value = '0;
		row_typed = 1'b0;
		row_want = '0;
		arst_n = 1'b0;
		idle_pct = 17;
		for (int i = 0; i < CAP; i++) begin
			slot_val[i] = '0;
			slot_link[i] = 7'(i + 1);
		end
		for (int i = 0; i < NSTK; i++) stack_top[i] = NULL_SLOT;
		free_head = '0;

		put_row(FUNC_POP, 0, 0, 1, 1, UNDERFLOW_VALUE, STATUS_UNDERFLOW, 0, 1);
		put_row(FUNC_PUSH, 7, 32'h7FFF_FFFF, 1, 1, 0, STATUS_DONE, 0, 0);
		put_row(FUNC_PUSH, 7, 32'h8000_0000, 1, 1, 0, STATUS_DONE, 0, 0);
		put_row(FUNC_POP, 7, 0, 1, 1, 32'h8000_0000, STATUS_DONE, 0, 0);
		put_row(FUNC_POP, 7, 32'hFFFF_FFFF, 1, 1, 32'h7FFF_FFFF, STATUS_DONE, 0, 1);
		put_row(FUNC_POP, 7, 0, 1, 1, UNDERFLOW_VALUE, STATUS_UNDERFLOW, 0, 1);
		put_row(FUNC_PUSH, 3, 0, 1, 0, 0, STATUS_DONE, 0, 0);
		put_row(FUNC_PUSH, 3, 32'hFFFF_FFFF, 1, 0, 0, STATUS_DONE, 0, 0);
		put_row(FUNC_PUSH, 0, 32'h5555_AAAA, 1, 0, 0, STATUS_DONE, 0, 0);
		put_row(FUNC_POP, 3, 0, 1, 1, 32'hFFFF_FFFF, STATUS_DONE, 0, 0);
		put_row(FUNC_PUSH, 1, 32'hAAAA_5555, 1, 0, 0, STATUS_DONE, 0, 0);
		put_row(FUNC_POP, 0, 0, 1, 0, 0, STATUS_DONE, 0, 0);
		put_row(FUNC_POP, 3, 0, 1, 0, 0, STATUS_DONE, 0, 0);
		put_row(FUNC_POP, 1, 0, 1, 0, 0, STATUS_DONE, 0, 0);
		put_row(FUNC_PUSH, 5, 32'h1000, CAP, 0, 0, STATUS_DONE, 0, 0);
		put_row(FUNC_PUSH, 5, 32'h2222, 1, 1, 0, STATUS_OVERFLOW, 1, 0);
		put_row(FUNC_PUSH, 2, 32'h1234, 1, 1, 0, STATUS_OVERFLOW, 1, 1);
		put_row(FUNC_POP, 2, 0, 1, 1, UNDERFLOW_VALUE, STATUS_UNDERFLOW, 1, 1);
		put_row(FUNC_POP, 5, 0, 1, 0, 0, STATUS_DONE, 0, 0);
		put_row(FUNC_PUSH, 6, 32'hFFFF_FFFB, 1, 0, 0, STATUS_DONE, 0, 0);
		put_row(FUNC_POP, 6, 0, 1, 0, 0, STATUS_DONE, 0, 0);
		put_row(FUNC_PUSH, 4, 32'h0F0F_0F0F, 1, 0, 0, STATUS_DONE, 0, 0);
		put_row(FUNC_POP, 4, 0, 1, 0, 0, STATUS_DONE, 0, 0);
		put_row(FUNC_POP, 5, 0, CAP - 1, 0, 0, STATUS_DONE, 0, 0);
		put_row(FUNC_POP, 5, 0, 1, 1, UNDERFLOW_VALUE, STATUS_UNDERFLOW, 0, 1);

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i])
			for (int k = 0; k < dir_rows[i].reps; k++)
				issue(dir_rows[i].f, dir_rows[i].sid, dir_rows[i].val + k,
					dir_rows[i].typed, dir_rows[i].want);
		wait_drained();

		// Segments with a biased push rate drive the store through full and empty
		// states; some segments stay on a single stack to build deep chains.
		for (int phase = 0; phase < 3; phase++) begin
			idle_pct = (phase == 0) ? 17 : (phase == 1) ? 54 : 0;
			phase_items = 0;
			seg_left = 0;
			while (phase_items < 350) begin
				if (seg_left == 0) begin
					seg_left = $urandom_range(20, 60);
					case ($urandom_range(0, 3))
						0: push_pct = 10;
						1: push_pct = 50;
						2: push_pct = 75;
						default: push_pct = 97;
					endcase
					fixed_sid = ($urandom_range(0, 2) == 0) ? $urandom_range(0, NSTK - 1) : -1;
				end
				f = ($urandom_range(0, 99) < push_pct) ? FUNC_PUSH : FUNC_POP;
				sid = (fixed_sid < 0) ? SID_W'($urandom_range(0, 7)) : SID_W'(fixed_sid);
				issue(f, sid, pick_value(), 0, '0);
				seg_left--;
				phase_items++;
			end
			wait_drained();
		end

		if (pending_results.size() != 0) begin
			n_err += pending_results.size();
			$display("%0d expected results never arrived", pending_results.size());
		end
		$display("Checked %0d results from %0d pushes and %0d pops across three idle settings.",
			n_checked, n_push, n_pop);
		$display("Saw %0d overflows, %0d underflows and %0d results with the store full.",
			n_over, n_under, n_full);
		if (n_err == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("%0d mismatches in total", n_err);
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
